### sv/pwb_pkg.sv
// Package for the particle wall bounce integrator.
// Widths, register indexes, reset values and small arithmetic helpers.
// No dependencies.
package pwb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int GAIN_FRAC  = 16;
    localparam int WORD_W     = 32;
    localparam int CNT_W      = 5;
    localparam int RAD_W      = 31;
    localparam int ET_W       = 21;
    localparam int GAIN_W     = 17;
    localparam int ACC_W      = 24;
    localparam int TS_W       = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int DTP_W      = ET_W + TS_W;
    localparam int DT_W       = WORD_W - 1;
    localparam int SAT_W      = 72;
    localparam int CMP_W      = WORD_W + 2;
    localparam int DPROD_W    = WORD_W + GAIN_W;
    localparam int GPROD_W    = ACC_W + DT_W + 1;
    localparam int XPROD_W    = 2 * WORD_W;
    localparam int YPROD_W    = 2 * WORD_W + 1;

    // radius / 80 = (radius >> 4) / 5, the /5 done by reciprocal multiply
    localparam int PUSH_PRE_SHIFT = 4;
    localparam int PUSH_Q_W       = RAD_W - PUSH_PRE_SHIFT;
    localparam int RECIP5_W       = 32;
    localparam int RECIP5_SHIFT   = 34;
    localparam logic [RECIP5_W-1:0] RECIP5 = 32'hCCCC_CCCD;
    localparam int PUSHP_W        = PUSH_Q_W + RECIP5_W;
    localparam int PUSH_W         = PUSHP_W - RECIP5_SHIFT;

    // c * 4 / 5 == (c * 820) >> 10 for the 5 bit count range
    localparam int DECAY_MUL   = 820;
    localparam int DECAY_SHIFT = 10;
    localparam int DECAY_W     = CNT_W + DECAY_SHIFT;

    localparam logic [CNT_W-1:0] STRAY_LIMIT   = CNT_W'(10);
    localparam logic [CNT_W-1:0] STRAY_HIT_ADD = CNT_W'(8);
    localparam logic [CNT_W-1:0] STRAY_MAX     = {CNT_W{1'b1}};

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W:0] MAG_POS_MAX = {2'b00, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W:0] MAG_NEG_MAX = {2'b01, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W:0] KICK        = (WORD_W+1)'(10 << FRAC_BITS);

    localparam logic signed [WORD_W-1:0] RST_LEFT_BOUND   = 32'sd655360;
    localparam logic signed [WORD_W-1:0] RST_BOTTOM_BOUND = 32'sd655360;
    localparam logic signed [WORD_W-1:0] RST_RIGHT_BOUND  = 32'sd6553600;
    localparam logic signed [WORD_W-1:0] RST_TOP_BOUND    = 32'sd6553600;
    localparam logic [GAIN_W-1:0]        RST_BOUNCE_GAIN  = 17'd32768;
    localparam logic signed [ACC_W-1:0]  RST_GRAVITY      = -24'sd642253;
    localparam logic [TS_W-1:0]          RST_TIME_SCALE   = 24'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_BOUND   = 3'd0,
        CFG_BOTTOM_BOUND = 3'd1,
        CFG_RIGHT_BOUND  = 3'd2,
        CFG_TOP_BOUND    = 3'd3,
        CFG_BOUNCE_GAIN  = 3'd4,
        CFG_GRAVITY      = 3'd5,
        CFG_TIME_SCALE   = 3'd6
    } t_cfg_idx;

    // wall hit flags of one axis: lo = left/bottom, hi = right/top
    typedef struct packed {
        logic lo;
        logic hi;
    } t_hit;

    function automatic logic signed [WORD_W-1:0] sat_word(input logic signed [SAT_W-1:0] v);
        if (v > SAT_W'(WORD_MAX)) begin
            return WORD_MAX;
        end else if (v < SAT_W'(WORD_MIN)) begin
            return WORD_MIN;
        end
        return v[WORD_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] stray_hit(input logic [CNT_W-1:0] c);
        logic [CNT_W:0] s;
        s = {1'b0, c} + {1'b0, STRAY_HIT_ADD};
        return (s > {1'b0, STRAY_MAX}) ? STRAY_MAX : s[CNT_W-1:0];
    endfunction

    function automatic logic [CNT_W-1:0] stray_decay(input logic [CNT_W-1:0] c);
        logic [DECAY_W-1:0] p;
        p = DECAY_W'(c) * DECAY_W'(DECAY_MUL);
        return CNT_W'(p >> DECAY_SHIFT);
    endfunction

    function automatic logic [CNT_W-1:0] stray_next(input logic [CNT_W-1:0] c,
                                                    input logic hit_x,
                                                    input logic hit_y);
        logic [CNT_W-1:0] c0;
        logic [CNT_W-1:0] c1;
        c0 = (c > STRAY_LIMIT) ? '0 : c;
        c1 = hit_x ? stray_hit(c0) : stray_decay(c0);
        return hit_y ? stray_hit(c1) : stray_decay(c1);
    endfunction

    // speed magnitude going into the damping multiply, rescue kick included
    function automatic logic [WORD_W-1:0] kick_mag(input logic signed [WORD_W-1:0] v,
                                                   input t_hit hit,
                                                   input logic kick);
        logic [WORD_W-1:0] a;
        logic [WORD_W:0]   k;
        a = v[WORD_W-1] ? WORD_W'(-v) : WORD_W'(v);
        k = {1'b0, a} + KICK;
        if (kick && hit.lo) begin
            return (k > MAG_POS_MAX) ? MAG_POS_MAX[WORD_W-1:0] : k[WORD_W-1:0];
        end else if (kick && hit.hi) begin
            return (k > MAG_NEG_MAX) ? MAG_NEG_MAX[WORD_W-1:0] : k[WORD_W-1:0];
        end
        return a;
    endfunction

endpackage

### sv/particle_wall_bounce_integrator.sv
// A request taken at a clock edge shows its result on the outputs, with o_done high for
// one cycle, after it has passed the 8 register stages (wall tests, kick/push, damp
// multiply, damp clamp, gravity add and x product, x update and y speed sum, y product,
// y update). Throughput: one request per cycle, o_busy stays low and the receiver cannot
// stall. Synchronous active-low reset clears the valid bits and loads the register
// defaults; data registers are not reset.
module particle_wall_bounce_integrator
    import pwb_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [WORD_W-1:0]        i_cfg_wdata,
    input  logic signed [WORD_W-1:0] i_in_x_pos,
    input  logic signed [WORD_W-1:0] i_in_y_pos,
    input  logic signed [WORD_W-1:0] i_in_x_vel,
    input  logic signed [WORD_W-1:0] i_in_y_vel,
    input  logic [RAD_W-1:0]         i_in_radius,
    input  logic [CNT_W-1:0]         i_in_stray_count,
    input  logic [ET_W-1:0]          i_elapsed_time,
    output logic                     o_done,
    output logic signed [WORD_W-1:0] o_out_x_pos,
    output logic signed [WORD_W-1:0] o_out_y_pos,
    output logic signed [WORD_W-1:0] o_out_x_vel,
    output logic signed [WORD_W-1:0] o_out_y_vel,
    output logic [CNT_W-1:0]         o_out_stray_count
);

    // configuration
    logic signed [WORD_W-1:0] r_left_bound;
    logic signed [WORD_W-1:0] r_bottom_bound;
    logic signed [WORD_W-1:0] r_right_bound;
    logic signed [WORD_W-1:0] r_top_bound;
    logic [GAIN_W-1:0]        r_bounce_gain;
    logic signed [ACC_W-1:0]  r_gravity;
    logic [TS_W-1:0]          r_time_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_bound   <= RST_LEFT_BOUND;
            r_bottom_bound <= RST_BOTTOM_BOUND;
            r_right_bound  <= RST_RIGHT_BOUND;
            r_top_bound    <= RST_TOP_BOUND;
            r_bounce_gain  <= RST_BOUNCE_GAIN;
            r_gravity      <= RST_GRAVITY;
            r_time_scale   <= RST_TIME_SCALE;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_LEFT_BOUND:   r_left_bound   <= signed'(i_cfg_wdata);
                CFG_BOTTOM_BOUND: r_bottom_bound <= signed'(i_cfg_wdata);
                CFG_RIGHT_BOUND:  r_right_bound  <= signed'(i_cfg_wdata);
                CFG_TOP_BOUND:    r_top_bound    <= signed'(i_cfg_wdata);
                CFG_BOUNCE_GAIN:  r_bounce_gain  <= i_cfg_wdata[GAIN_W-1:0];
                CFG_GRAVITY:      r_gravity      <= signed'(i_cfg_wdata[ACC_W-1:0]);
                CFG_TIME_SCALE:   r_time_scale   <= i_cfg_wdata[TS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // valid chain
    logic r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic r_s5_valid, r_s6_valid, r_s7_valid, r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
            r_s6_valid <= 1'b0;
            r_s7_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_s1_valid <= i_start && !o_busy;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
            r_s6_valid <= r_s5_valid;
            r_s7_valid <= r_s6_valid;
            r_done     <= r_s7_valid;
        end
    end

    // stage 1: wall tests, dt product, radius/80 product
    logic signed [CMP_W-1:0] w_x_ext, w_y_ext, w_r_ext;
    t_hit                    n_s1_hit_x, n_s1_hit_y;
    logic [PUSHP_W-1:0]      n_s1_pushp;

    always_comb begin
        w_x_ext = CMP_W'(i_in_x_pos);
        w_y_ext = CMP_W'(i_in_y_pos);
        w_r_ext = CMP_W'(signed'({1'b0, i_in_radius}));
        n_s1_hit_x.lo = (w_x_ext - w_r_ext) < CMP_W'(r_left_bound);
        n_s1_hit_x.hi = !n_s1_hit_x.lo && ((w_x_ext + w_r_ext) > CMP_W'(r_right_bound));
        n_s1_hit_y.lo = (w_y_ext - w_r_ext) < CMP_W'(r_bottom_bound);
        n_s1_hit_y.hi = !n_s1_hit_y.lo && ((w_y_ext + w_r_ext) > CMP_W'(r_top_bound));
        n_s1_pushp = PUSHP_W'(i_in_radius >> PUSH_PRE_SHIFT) * PUSHP_W'(RECIP5);
    end

    logic signed [WORD_W-1:0] r_s1_x, r_s1_y, r_s1_vx, r_s1_vy;
    logic [CNT_W-1:0]         r_s1_cnt;
    t_hit                     r_s1_hit_x, r_s1_hit_y;
    logic [DTP_W-1:0]         r_s1_dtp;
    logic [PUSH_W-1:0]        r_s1_push;

    always_ff @(posedge i_clk) begin
        r_s1_x     <= i_in_x_pos;
        r_s1_y     <= i_in_y_pos;
        r_s1_vx    <= i_in_x_vel;
        r_s1_vy    <= i_in_y_vel;
        r_s1_cnt   <= i_in_stray_count;
        r_s1_hit_x <= n_s1_hit_x;
        r_s1_hit_y <= n_s1_hit_y;
        r_s1_dtp   <= DTP_W'(i_elapsed_time) * DTP_W'(r_time_scale);
        r_s1_push  <= n_s1_pushp[PUSHP_W-1:RECIP5_SHIFT];
    end

    // stage 2: kicked magnitudes, pushed positions, dt, new count
    logic                     w_kick;
    logic signed [SAT_W-1:0]  w_push_ext;
    logic [DTP_W-1:0]         w_dt_sh;
    logic [WORD_W-1:0]        n_s2_mag_x, n_s2_mag_y;
    logic signed [WORD_W-1:0] n_s2_x_p, n_s2_y_p;
    logic [DT_W-1:0]          n_s2_dt;

    always_comb begin
        w_kick     = r_s1_cnt > STRAY_LIMIT;
        w_push_ext = SAT_W'(signed'({1'b0, r_s1_push}));
        n_s2_mag_x = kick_mag(r_s1_vx, r_s1_hit_x, w_kick);
        n_s2_mag_y = kick_mag(r_s1_vy, r_s1_hit_y, w_kick);
        if (r_s1_hit_x.lo) begin
            n_s2_x_p = sat_word(SAT_W'(r_s1_x) + w_push_ext);
        end else if (r_s1_hit_x.hi) begin
            n_s2_x_p = sat_word(SAT_W'(r_s1_x) - w_push_ext);
        end else begin
            n_s2_x_p = r_s1_x;
        end
        if (r_s1_hit_y.lo) begin
            n_s2_y_p = sat_word(SAT_W'(r_s1_y) + w_push_ext);
        end else if (r_s1_hit_y.hi) begin
            n_s2_y_p = sat_word(SAT_W'(r_s1_y) - w_push_ext);
        end else begin
            n_s2_y_p = r_s1_y;
        end
        w_dt_sh = r_s1_dtp >> FRAC_BITS;
        n_s2_dt = (w_dt_sh > DTP_W'({DT_W{1'b1}})) ? {DT_W{1'b1}} : w_dt_sh[DT_W-1:0];
    end

    logic [WORD_W-1:0]        r_s2_mag_x, r_s2_mag_y;
    logic signed [WORD_W-1:0] r_s2_vx, r_s2_vy, r_s2_x_p, r_s2_y_p;
    t_hit                     r_s2_hit_x, r_s2_hit_y;
    logic [DT_W-1:0]          r_s2_dt;
    logic [CNT_W-1:0]         r_s2_cnt;

    always_ff @(posedge i_clk) begin
        r_s2_mag_x <= n_s2_mag_x;
        r_s2_mag_y <= n_s2_mag_y;
        r_s2_vx    <= r_s1_vx;
        r_s2_vy    <= r_s1_vy;
        r_s2_x_p   <= n_s2_x_p;
        r_s2_y_p   <= n_s2_y_p;
        r_s2_hit_x <= r_s1_hit_x;
        r_s2_hit_y <= r_s1_hit_y;
        r_s2_dt    <= n_s2_dt;
        r_s2_cnt   <= stray_next(r_s1_cnt, r_s1_hit_x.lo | r_s1_hit_x.hi,
                                 r_s1_hit_y.lo | r_s1_hit_y.hi);
    end

    // stages 3-4: damping (in pwb_damp) and gravity product
    logic signed [WORD_W-1:0] w_vx_f, w_vy_f;

    pwb_damp u_damp_x (
        .i_clk  (i_clk),
        .i_mag  (r_s2_mag_x),
        .i_gain (r_bounce_gain),
        .i_hit  (r_s2_hit_x),
        .i_vel  (r_s2_vx),
        .o_vel  (w_vx_f)
    );

    pwb_damp u_damp_y (
        .i_clk  (i_clk),
        .i_mag  (r_s2_mag_y),
        .i_gain (r_bounce_gain),
        .i_hit  (r_s2_hit_y),
        .i_vel  (r_s2_vy),
        .o_vel  (w_vy_f)
    );

    logic signed [WORD_W-1:0]  r_s3_x_p, r_s3_y_p, r_s4_x_p, r_s4_y_p;
    logic [DT_W-1:0]           r_s3_dt, r_s4_dt;
    logic [CNT_W-1:0]          r_s3_cnt, r_s4_cnt;
    logic signed [GPROD_W-1:0] r_s3_gprod, r_s4_gprod;

    always_ff @(posedge i_clk) begin
        r_s3_x_p   <= r_s2_x_p;
        r_s3_y_p   <= r_s2_y_p;
        r_s3_dt    <= r_s2_dt;
        r_s3_cnt   <= r_s2_cnt;
        r_s3_gprod <= GPROD_W'(r_gravity) * GPROD_W'(signed'({1'b0, r_s2_dt}));
        r_s4_x_p   <= r_s3_x_p;
        r_s4_y_p   <= r_s3_y_p;
        r_s4_dt    <= r_s3_dt;
        r_s4_cnt   <= r_s3_cnt;
        r_s4_gprod <= r_s3_gprod;
    end

    // stage 5: gravity add, x displacement product
    logic signed [WORD_W-1:0]  r_s5_x_p, r_s5_y_p, r_s5_vx_f, r_s5_vy_f, r_s5_vy_g;
    logic [DT_W-1:0]           r_s5_dt;
    logic [CNT_W-1:0]          r_s5_cnt;
    logic signed [XPROD_W-1:0] r_s5_xprod;

    always_ff @(posedge i_clk) begin
        r_s5_x_p   <= r_s4_x_p;
        r_s5_y_p   <= r_s4_y_p;
        r_s5_vx_f  <= w_vx_f;
        r_s5_vy_f  <= w_vy_f;
        r_s5_vy_g  <= sat_word(SAT_W'(w_vy_f) + SAT_W'(r_s4_gprod >>> FRAC_BITS));
        r_s5_dt    <= r_s4_dt;
        r_s5_cnt   <= r_s4_cnt;
        r_s5_xprod <= XPROD_W'(signed'({1'b0, r_s4_dt})) * XPROD_W'(w_vx_f);
    end

    // stage 6: x position, y speed sum (old + new)
    logic signed [WORD_W-1:0] r_s6_y_p, r_s6_vx_f, r_s6_vy_g, r_s6_x_new;
    logic signed [WORD_W:0]   r_s6_ysum;
    logic [DT_W-1:0]          r_s6_dt;
    logic [CNT_W-1:0]         r_s6_cnt;

    always_ff @(posedge i_clk) begin
        r_s6_y_p   <= r_s5_y_p;
        r_s6_vx_f  <= r_s5_vx_f;
        r_s6_vy_g  <= r_s5_vy_g;
        r_s6_x_new <= sat_word(SAT_W'(r_s5_x_p) + SAT_W'(r_s5_xprod >>> FRAC_BITS));
        r_s6_ysum  <= (WORD_W+1)'(r_s5_vy_f) + (WORD_W+1)'(r_s5_vy_g);
        r_s6_dt    <= r_s5_dt;
        r_s6_cnt   <= r_s5_cnt;
    end

    // stage 7: y displacement product
    logic signed [WORD_W-1:0]  r_s7_y_p, r_s7_vx_f, r_s7_vy_g, r_s7_x_new;
    logic signed [YPROD_W-1:0] r_s7_yprod;
    logic [CNT_W-1:0]          r_s7_cnt;

    always_ff @(posedge i_clk) begin
        r_s7_y_p   <= r_s6_y_p;
        r_s7_vx_f  <= r_s6_vx_f;
        r_s7_vy_g  <= r_s6_vy_g;
        r_s7_x_new <= r_s6_x_new;
        r_s7_cnt   <= r_s6_cnt;
        r_s7_yprod <= YPROD_W'(signed'({1'b0, r_s6_dt})) * YPROD_W'(r_s6_ysum);
    end

    // stage 8: y position, output registers
    logic signed [WORD_W-1:0] r_out_x_pos, r_out_y_pos, r_out_x_vel, r_out_y_vel;
    logic [CNT_W-1:0]         r_out_cnt;

    always_ff @(posedge i_clk) begin
        r_out_x_pos <= r_s7_x_new;
        r_out_y_pos <= sat_word(SAT_W'(r_s7_y_p) + SAT_W'(r_s7_yprod >>> (FRAC_BITS + 1)));
        r_out_x_vel <= r_s7_vx_f;
        r_out_y_vel <= r_s7_vy_g;
        r_out_cnt   <= r_s7_cnt;
    end

    assign o_done            = r_done;
    assign o_out_x_pos       = r_out_x_pos;
    assign o_out_y_pos       = r_out_y_pos;
    assign o_out_x_vel       = r_out_x_vel;
    assign o_out_y_vel       = r_out_y_vel;
    assign o_out_stray_count = r_out_cnt;

endmodule

### sv/pwb_damp.sv
// Two stage wall damping for one axis: |v| * gain, then clamp and sign.
// Depends on pwb_pkg.
module pwb_damp
    import pwb_pkg::*;
(
    input  logic                     i_clk,
    input  logic [WORD_W-1:0]        i_mag,
    input  logic [GAIN_W-1:0]        i_gain,
    input  t_hit                     i_hit,
    input  logic signed [WORD_W-1:0] i_vel,
    output logic signed [WORD_W-1:0] o_vel
);

    logic [DPROD_W-1:0]        r_prod;
    t_hit                      r_hit;
    logic signed [WORD_W-1:0]  r_vel;
    logic signed [WORD_W-1:0]  r_out;

    logic [DPROD_W-GAIN_FRAC-1:0] w_sh;
    logic signed [WORD_W-1:0]     w_damp;
    logic signed [WORD_W-1:0]     n_out;

    always_ff @(posedge i_clk) begin
        r_prod <= DPROD_W'(i_mag) * DPROD_W'(i_gain);
        r_hit  <= i_hit;
        r_vel  <= i_vel;
        r_out  <= n_out;
    end

    always_comb begin
        w_sh   = r_prod[DPROD_W-1:GAIN_FRAC];
        w_damp = (w_sh > (DPROD_W-GAIN_FRAC)'(MAG_POS_MAX)) ? WORD_MAX
                                                           : signed'(w_sh[WORD_W-1:0]);
        if (r_hit.lo) begin
            n_out = w_damp;
        end else if (r_hit.hi) begin
            n_out = -w_damp;
        end else begin
            n_out = r_vel;
        end
    end

    assign o_vel = r_out;

endmodule

### sv/pwb_checker.sv
// Port level checks for particle_wall_bounce_integrator, bound to the top level.
// Depends on pwb_pkg.
module pwb_checker
    import pwb_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_start,
    input logic                     o_busy,
    input logic                     i_cfg_wr_en,
    input logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input logic [WORD_W-1:0]        i_cfg_wdata,
    input logic [CNT_W-1:0]         i_in_stray_count,
    input logic                     o_done,
    input logic [CNT_W-1:0]         o_out_stray_count
);

    localparam int LATENCY = 8;
    // count entering the wall stage is at most 10, so two hits reach at most 26
    localparam logic [CNT_W-1:0] CNT_OUT_MAX  = CNT_W'(26);
    // a rescued particle restarts from zero: at most two hits of 8
    localparam logic [CNT_W-1:0] CNT_KICK_MAX = CNT_W'(16);

    a_done_has_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy && i_rst_n, LATENCY))
        else $error("result without a matching request");

    // first edge with reset released after a reset cycle
    a_no_done_after_reset: assert property (@(posedge i_clk)
        ($past(!i_rst_n) && i_rst_n) |-> !o_done)
        else $error("result strobe right after reset");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_out_stray_count <= CNT_OUT_MAX))
        else $error("stray count out of reachable range");

    a_kick_clears_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && ($past(i_in_stray_count, LATENCY) > STRAY_LIMIT))
            |-> (o_out_stray_count <= CNT_KICK_MAX))
        else $error("stray count not cleared by rescue");

endmodule

bind particle_wall_bounce_integrator pwb_checker u_pwb_checker (.*);
